[design/rgb_to_yuv420_converter_assert.svh]
// Assertion macros for the RGB to YUV 4:2:0 converter.
// Each takes a label, clock, active-low reset, antecedent, consequent and message.
`ifndef RGB_TO_YUV420_CONVERTER_ASSERT_SVH
`define RGB_TO_YUV420_CONVERTER_ASSERT_SVH

`ifndef ASSERT_OFF

`define RYUV_ASSERT_SAME(lbl, clk, rst_n, ante, cons, msg) \
  lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
    else $error(msg);

`define RYUV_ASSERT_NEXT(lbl, clk, rst_n, ante, cons, msg) \
  lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
    else $error(msg);

`else

`define RYUV_ASSERT_SAME(lbl, clk, rst_n, ante, cons, msg)

`define RYUV_ASSERT_NEXT(lbl, clk, rst_n, ante, cons, msg)

`endif

`endif

[design/ryuv_pkg.sv]
package ryuv_pkg;

  localparam int MAX_WIDTH      = 2048;
  localparam int COEF_FRAC_BITS = 16;
  localparam int MAX_ROWS       = 4096;
  localparam int LINE_DEPTH     = MAX_WIDTH / 2;
  localparam int LINE_ADDR_W    = $clog2(LINE_DEPTH);

  localparam int COL_W       = 11;
  localparam int ROW_W       = 12;
  localparam int WIDTH_W     = 12;
  localparam int HEIGHT_W    = 13;
  localparam int CFG_DATA_W  = 13;
  localparam int CFG_INDEX_W = 1;
  localparam int PAIR_W      = 9;

  localparam logic [CFG_INDEX_W-1:0] CFG_IMAGE_WIDTH  = 1'b0;
  localparam logic [CFG_INDEX_W-1:0] CFG_IMAGE_HEIGHT = 1'b1;

  localparam logic [WIDTH_W-1:0]  WIDTH_RESET  = 12'd640;
  localparam logic [HEIGHT_W-1:0] HEIGHT_RESET = 13'd480;

  // weights rounded to COEF_FRAC_BITS fraction bits
  localparam longint K_Y_R = ((longint'(2990) << COEF_FRAC_BITS) + 5000) / 10000;
  localparam longint K_Y_G = ((longint'(5870) << COEF_FRAC_BITS) + 5000) / 10000;
  localparam longint K_Y_B = ((longint'(1140) << COEF_FRAC_BITS) + 5000) / 10000;
  localparam longint K_U_R = ((longint'(1684) << COEF_FRAC_BITS) + 5000) / 10000;
  localparam longint K_U_G = ((longint'(3316) << COEF_FRAC_BITS) + 5000) / 10000;
  localparam longint K_V_G = ((longint'(4187) << COEF_FRAC_BITS) + 5000) / 10000;
  localparam longint K_V_B = ((longint'(813)  << COEF_FRAC_BITS) + 5000) / 10000;

  typedef struct packed {
    logic [7:0] blue;
    logic [7:0] green;
    logic [7:0] red;
  } pixel_t;

  typedef struct packed {
    logic [7:0] y;
    logic [7:0] u;
    logic [7:0] v;
  } yuv_t;

  typedef struct packed {
    logic [PAIR_W-1:0] u;
    logic [PAIR_W-1:0] v;
  } pair_t;

endpackage

[design/ryuv_color_xform.sv]
module ryuv_color_xform (
  input  ryuv_pkg::pixel_t pix,
  output ryuv_pkg::yuv_t   yuv
);

  localparam int F      = ryuv_pkg::COEF_FRAC_BITS;
  localparam int PROD_W = F + 8;
  localparam int SUM_W  = F + 10;
  localparam int S_W    = F + 11;

  logic [PROD_W-1:0] p_y_r, p_y_g, p_y_b;
  logic [PROD_W-1:0] p_u_r, p_u_g, p_v_g, p_v_b;
  logic [SUM_W-1:0]  y_sum;
  logic [S_W-1:0]    u_base, v_base, u_sum, v_sum;
  logic [9:0]        y_int, u_int, v_int;

  assign p_y_r = PROD_W'(pix.red)   * PROD_W'(ryuv_pkg::K_Y_R);
  assign p_y_g = PROD_W'(pix.green) * PROD_W'(ryuv_pkg::K_Y_G);
  assign p_y_b = PROD_W'(pix.blue)  * PROD_W'(ryuv_pkg::K_Y_B);
  assign p_u_r = PROD_W'(pix.red)   * PROD_W'(ryuv_pkg::K_U_R);
  assign p_u_g = PROD_W'(pix.green) * PROD_W'(ryuv_pkg::K_U_G);
  assign p_v_g = PROD_W'(pix.green) * PROD_W'(ryuv_pkg::K_V_G);
  assign p_v_b = PROD_W'(pix.blue)  * PROD_W'(ryuv_pkg::K_V_B);

  assign y_sum = SUM_W'(p_y_r) + SUM_W'(p_y_g) + SUM_W'(p_y_b);

  // integer part (half component + 128) placed above the fraction bits
  assign u_base = S_W'({9'(pix.blue[7:1]) + 9'd128, {F{1'b0}}});
  assign v_base = S_W'({9'(pix.red[7:1]) + 9'd128, {F{1'b0}}});
  assign u_sum  = u_base - S_W'(p_u_r) - S_W'(p_u_g);
  assign v_sum  = v_base - S_W'(p_v_g) - S_W'(p_v_b);

  assign y_int = y_sum[SUM_W-1:F];
  assign u_int = u_sum[S_W-2:F];
  assign v_int = v_sum[S_W-2:F];

  // clamp to 0..255; negative when the sign bit is set
  always_comb begin
    yuv.y = (y_int > 10'd255) ? 8'hFF : y_int[7:0];
    if (u_sum[S_W-1]) begin
      yuv.u = 8'h00;
    end else begin
      yuv.u = (u_int > 10'd255) ? 8'hFF : u_int[7:0];
    end
    if (v_sum[S_W-1]) begin
      yuv.v = 8'h00;
    end else begin
      yuv.v = (v_int > 10'd255) ? 8'hFF : v_int[7:0];
    end
  end

endmodule

[design/ryuv_line_store.sv]
module ryuv_line_store (
  input  logic                             clk,
  input  logic                             wr_en,
  input  logic [ryuv_pkg::LINE_ADDR_W-1:0] wr_addr,
  input  ryuv_pkg::pair_t                  wr_data,
  input  logic                             rd_en,
  input  logic [ryuv_pkg::LINE_ADDR_W-1:0] rd_addr,
  output ryuv_pkg::pair_t                  rd_data
);

  ryuv_pkg::pair_t mem_r [ryuv_pkg::LINE_DEPTH];
  ryuv_pkg::pair_t rd_data_r;

  always_ff @(posedge clk) begin
    if (wr_en) begin
      mem_r[wr_addr] <= wr_data;
    end
  end

  always_ff @(posedge clk) begin
    if (rd_en) begin
      rd_data_r <= mem_r[rd_addr];
    end
  end

  assign rd_data = rd_data_r;

endmodule

[design/rgb_to_yuv420_converter.sv]
// channel  | direction | handshake          | payload
// ---------+-----------+--------------------+-------------------------------------------
// in_      | input     | in_valid/in_ready  | in_blue, in_green, in_red
// out_     | output    | out_valid/out_ready| out_luma, out_chroma_valid, out_chroma_u/v
// cfg_     | input     | cfg_wr_en          | cfg_index, cfg_data
//
// One pixel per cycle sustained while out_ready is high; out_valid rises after an
// accepted request passes the pixel register, then the result register.
// The line store read is issued at acceptance so its registered data lines up with the
// pixel register; the write (odd column, even row) happens when that pixel moves on.
// Synchronous active-low reset clears counters, held chroma, s1_v_r and out_valid_r;
// the line store is not cleared. Back-pressure on out_ready stalls both stages.
`include "rgb_to_yuv420_converter_assert.svh"

module rgb_to_yuv420_converter (
  input  logic                              clk,
  input  logic                              rst_n,
  input  logic                              in_valid,
  output logic                              in_ready,
  input  logic [7:0]                        in_blue,
  input  logic [7:0]                        in_green,
  input  logic [7:0]                        in_red,
  output logic                              out_valid,
  input  logic                              out_ready,
  output logic [7:0]                        out_luma,
  output logic                              out_chroma_valid,
  output logic [7:0]                        out_chroma_u,
  output logic [7:0]                        out_chroma_v,
  input  logic                              cfg_wr_en,
  input  logic [ryuv_pkg::CFG_INDEX_W-1:0]  cfg_index,
  input  logic [ryuv_pkg::CFG_DATA_W-1:0]   cfg_data
);

  localparam int WIDTH_W  = ryuv_pkg::WIDTH_W;
  localparam int HEIGHT_W = ryuv_pkg::HEIGHT_W;
  localparam int ADDR_W   = ryuv_pkg::LINE_ADDR_W;
  localparam int PAIR_W   = ryuv_pkg::PAIR_W;

  logic [WIDTH_W-1:0]         width_r;
  logic [HEIGHT_W-1:0]        height_r;
  logic [WIDTH_W-1:0]         w_eff;
  logic [HEIGHT_W-1:0]        h_eff;
  logic [ryuv_pkg::COL_W-1:0] col_r;
  logic [ryuv_pkg::ROW_W-1:0] row_r;
  logic                       col_last, row_last;

  logic                       in_acc, s1_adv;
  logic                       s1_v_r;
  ryuv_pkg::pixel_t           s1_pix_r;
  logic                       s1_odd_col_r, s1_odd_row_r;
  logic [ADDR_W-1:0]          s1_slot_r;
  ryuv_pkg::pixel_t           in_pix;

  ryuv_pkg::yuv_t             yuv;
  ryuv_pkg::pair_t            line_rd, line_wr;
  logic                       line_wr_en;
  logic [7:0]                 held_u_r, held_v_r;
  logic [PAIR_W:0]            blk_u, blk_v;
  logic                       chroma_vld_nxt;
  logic [7:0]                 chroma_u_nxt, chroma_v_nxt;

  logic                       out_valid_r, out_chroma_valid_r;
  logic [7:0]                 out_luma_r, out_chroma_u_r, out_chroma_v_r;

  // configuration
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      width_r  <= ryuv_pkg::WIDTH_RESET;
      height_r <= ryuv_pkg::HEIGHT_RESET;
    end else if (cfg_wr_en) begin
      unique case (cfg_index)
        ryuv_pkg::CFG_IMAGE_WIDTH:  width_r  <= cfg_data[WIDTH_W-1:0];
        ryuv_pkg::CFG_IMAGE_HEIGHT: height_r <= cfg_data[HEIGHT_W-1:0];
        default: ;
      endcase
    end
  end

  // zero means one, and clamp to the supported maximum
  always_comb begin
    if (width_r == '0) begin
      w_eff = WIDTH_W'(1);
    end else if (width_r > ryuv_pkg::MAX_WIDTH) begin
      w_eff = WIDTH_W'(ryuv_pkg::MAX_WIDTH);
    end else begin
      w_eff = width_r;
    end
    if (height_r == '0) begin
      h_eff = HEIGHT_W'(1);
    end else if (height_r > ryuv_pkg::MAX_ROWS) begin
      h_eff = HEIGHT_W'(ryuv_pkg::MAX_ROWS);
    end else begin
      h_eff = height_r;
    end
  end

  assign col_last = (WIDTH_W'(col_r) + WIDTH_W'(1)) >= w_eff;
  assign row_last = (HEIGHT_W'(row_r) + HEIGHT_W'(1)) >= h_eff;

  // handshake
  assign s1_adv   = s1_v_r && (!out_valid_r || out_ready);
  assign in_ready = !s1_v_r || s1_adv;
  assign in_acc   = in_valid && in_ready;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      col_r <= '0;
      row_r <= '0;
    end else if (in_acc) begin
      if (col_last) begin
        col_r <= '0;
        row_r <= row_last ? '0 : row_r + 1'b1;
      end else begin
        col_r <= col_r + 1'b1;
      end
    end
  end

  assign in_pix.blue  = in_blue;
  assign in_pix.green = in_green;
  assign in_pix.red   = in_red;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      s1_v_r <= 1'b0;
    end else if (in_acc) begin
      s1_v_r <= 1'b1;
    end else if (s1_adv) begin
      s1_v_r <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (in_acc) begin
      s1_pix_r     <= in_pix;
      s1_odd_col_r <= col_r[0];
      s1_odd_row_r <= row_r[0];
      s1_slot_r    <= ADDR_W'(col_r >> 1);
    end
  end

  ryuv_color_xform u_xform (
    .pix (s1_pix_r),
    .yuv (yuv)
  );

  assign line_wr.u  = PAIR_W'(held_u_r) + PAIR_W'(yuv.u);
  assign line_wr.v  = PAIR_W'(held_v_r) + PAIR_W'(yuv.v);
  assign line_wr_en = s1_adv && s1_odd_col_r && !s1_odd_row_r;

  ryuv_line_store u_line (
    .clk     (clk),
    .wr_en   (line_wr_en),
    .wr_addr (s1_slot_r),
    .wr_data (line_wr),
    .rd_en   (in_acc),
    .rd_addr (ADDR_W'(col_r >> 1)),
    .rd_data (line_rd)
  );

  // 2x2 block sum: stored pair from the even row plus this row's pair
  assign blk_u = (PAIR_W+1)'(line_rd.u) + (PAIR_W+1)'(line_wr.u);
  assign blk_v = (PAIR_W+1)'(line_rd.v) + (PAIR_W+1)'(line_wr.v);

  assign chroma_vld_nxt = s1_odd_col_r && s1_odd_row_r;
  assign chroma_u_nxt   = chroma_vld_nxt ? blk_u[PAIR_W:2] : 8'h00;
  assign chroma_v_nxt   = chroma_vld_nxt ? blk_v[PAIR_W:2] : 8'h00;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      held_u_r <= '0;
      held_v_r <= '0;
    end else if (s1_adv) begin
      held_u_r <= yuv.u;
      held_v_r <= yuv.v;
    end
  end

  // result register
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      out_valid_r <= 1'b0;
    end else if (s1_adv) begin
      out_valid_r <= 1'b1;
    end else if (out_ready) begin
      out_valid_r <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (s1_adv) begin
      out_luma_r         <= yuv.y;
      out_chroma_valid_r <= chroma_vld_nxt;
      out_chroma_u_r     <= chroma_u_nxt;
      out_chroma_v_r     <= chroma_v_nxt;
    end
  end

  assign out_valid        = out_valid_r;
  assign out_luma         = out_luma_r;
  assign out_chroma_valid = out_chroma_valid_r;
  assign out_chroma_u     = out_chroma_u_r;
  assign out_chroma_v     = out_chroma_v_r;

  `RYUV_ASSERT_SAME(a_no_accept_when_full, clk, rst_n,
    s1_v_r && out_valid_r && !out_ready, !in_ready,
    "request accepted while both stages are stalled")
  `RYUV_ASSERT_NEXT(a_accept_fills_s1, clk, rst_n, in_acc, s1_v_r,
    "accepted request missing from pixel stage")
  `RYUV_ASSERT_SAME(a_chroma_zero, clk, rst_n, out_valid && !out_chroma_valid,
    out_chroma_u == 8'h00 && out_chroma_v == 8'h00,
    "chroma not zero without chroma_valid")
  `RYUV_ASSERT_SAME(a_write_xor_emit, clk, rst_n, line_wr_en, !chroma_vld_nxt,
    "line write and chroma result from the same pixel")

endmodule
